FILE: rtl/irwag_pkg.sv
// Shared types and constants for the idle-rate work-amount governor.
`default_nettype none

package irwag_pkg;

    // One input beat.
    typedef struct packed {
        logic        mode;
        logic [31:0] tick;
        logic        adjust_enable;
        logic        high_priority;
    } t_in_item;

    // One result beat.
    typedef struct packed {
        logic [15:0] work_amount;
        logic [15:0] idle_rate;
        logic        window_closed;
    } t_out_item;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_WINDOW_TICKS        = 3'd0,
        CFG_RATE_SCALE          = 3'd1,
        CFG_LOW_TARGET          = 3'd2,
        CFG_HIGH_TARGET         = 3'd3,
        CFG_LOW_PRIORITY_FACTOR = 3'd4,
        CFG_INITIAL_AMOUNT      = 3'd5
    } t_cfg_index;

    // Input mode codes.
    localparam logic MODE_IDLE      = 1'b0;
    localparam logic MODE_WORK_DONE = 1'b1;

    // Reset values of the configuration registers and of the block state.
    localparam logic [15:0] WINDOW_TICKS_RESET  = 16'd50;
    localparam logic [7:0]  RATE_SCALE_RESET    = 8'd2;
    localparam logic [7:0]  LOW_TARGET_RESET    = 8'd2;
    localparam logic [7:0]  HIGH_TARGET_RESET   = 8'd10;
    localparam logic [7:0]  LOW_PRIO_RESET      = 8'd5;
    localparam logic [15:0] INITIAL_AMOUNT_RESET = 16'd5;
    localparam logic [15:0] RATE_RESET          = 16'd2;

endpackage

`default_nettype wire

FILE: rtl/idle_rate_work_amount_governor.sv
// Top level of the idle-rate work-amount governor with its bit-serial datapath.
//
// Usage: each input beat on i_in_valid/i_in_item is either an idle event or a
// work-done event, and every accepted beat yields exactly one result beat on
// o_out_valid/o_out_item. An idle event counts towards the current window; the
// event whose tick reaches the window end closes the window, turns the count
// into an idle rate and, if adjustment is allowed, rescales the work amount.
// The user writes the configuration registers via i_cfg_we, i_cfg_index and
// i_cfg_data while the block is idle (not enforced); writes take effect at once.
//
// Timing: the block handles one beat at a time and holds o_in_stall high while
// it works. A work-done event or an idle event that leaves the window open
// goes straight to its result. A window close runs the 8-step serial multiply
// for the rate and both targets. Each amount adjustment adds a 16-step serial
// multiply and a 32-step restoring divide that share one accumulator, plus a
// fix-up step; a close may both shrink and grow. The result is loaded into the
// output register from the done state once that register is free.
//
// Reset (synchronous, active low) restores the configuration, state and control
// registers to their defaults and empties the output register. A stalled result
// is held in the output register while the next beat is already accepted and
// worked on; that beat then waits in its final step until the register is free.
`default_nettype none

module idle_rate_work_amount_governor (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  irwag_pkg::t_in_item     i_in_item,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output irwag_pkg::t_out_item    o_out_item,
    input  wire                     i_cfg_we,
    input  wire  [2:0]              i_cfg_index,
    input  wire  [15:0]             i_cfg_data
);
    import irwag_pkg::*;

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MULR = 7'b0000010,
        S_CHK  = 7'b0000100,
        S_MULA = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_FIX  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    // Last step of each serial phase.
    localparam logic [4:0] MULR_LAST = 5'd7;
    localparam logic [4:0] MULA_LAST = 5'd15;
    localparam logic [4:0] DIV_LAST  = 5'd31;

    // Configuration registers.
    logic [15:0] r_win;
    logic [7:0]  r_scale;
    logic [7:0]  r_low_t;
    logic [7:0]  r_high_t;
    logic [7:0]  r_lpf;
    logic [15:0] r_init;

    // Block state.
    logic [15:0] r_count;
    logic [15:0] r_rate;
    logic [31:0] r_window_end;
    logic [15:0] r_amount;

    // Sequencer control.
    t_state      r_state;
    logic [4:0]  r_cnt;
    logic        r_stage;   // 0 while the shrink test is due, 1 for the grow test
    logic        r_grow;
    logic        r_adj;
    logic        r_closed;
    logic        r_out_valid;

    // Serial datapath.
    logic [31:0] r_acc;     // product, then dividend shifting into quotient
    logic [15:0] r_mq;      // multiplier bits, taken from the top
    logic [15:0] r_mcand;
    logic [7:0]  r_fq;      // target factor bits, taken from the top
    logic [15:0] r_lo;
    logic [15:0] r_hi;
    logic [15:0] r_div;
    logic [15:0] r_rem;
    t_out_item   r_out;

    logic        accept;
    logic        closes;
    logic [15:0] cnt_inc;
    logic [31:0] n_acc_mul;
    logic [15:0] n_lo;
    logic [15:0] n_hi;
    logic [15:0] rate_sat;
    logic [16:0] div_shift;
    logic [17:0] div_diff;
    logic        div_q;
    logic [15:0] div_rem;
    logic [15:0] shrink_amt;
    logic [15:0] grow_amt;
    logic [15:0] quarter;
    logic [17:0] amt4;
    logic [31:0] grow_q;
    logic        load_out;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign accept  = i_in_valid && (r_state == S_IDLE);
    assign closes  = (i_in_item.tick >= r_window_end);
    assign cnt_inc = (r_count == 16'hFFFF) ? r_count : r_count + 16'd1;

    assign load_out = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // One shift-and-add step per cycle, most significant multiplier bit first.
    always_comb begin
        n_acc_mul = {r_acc[30:0], 1'b0} + (r_mq[15] ? {16'd0, r_mcand} : 32'd0);
        n_lo      = {r_lo[14:0], 1'b0} + (r_fq[7] ? {8'd0, r_low_t} : 16'd0);
        n_hi      = {r_hi[14:0], 1'b0} + (r_fq[7] ? {8'd0, r_high_t} : 16'd0);
        rate_sat  = (n_acc_mul[23:16] != 8'd0) ? 16'hFFFF : n_acc_mul[15:0];
    end

    // One restoring division step per cycle.
    always_comb begin
        div_shift = {r_rem, r_acc[31]};
        div_diff  = {1'b0, div_shift} - {2'b00, r_div};
        div_q     = !div_diff[17];
        div_rem   = div_q ? div_diff[15:0] : div_shift[15:0];
    end

    // Fix-up of the quotient for a shrink: floor at a quarter, force a change,
    // never drop to zero. With a zero target the quotient counts as zero.
    always_comb begin
        quarter    = r_amount >> 2;
        shrink_amt = (r_div == 16'd0) ? 16'd0 : r_acc[15:0];
        if (shrink_amt < quarter) begin
            shrink_amt = quarter;
        end
        if ((shrink_amt == r_amount) && (r_amount != 16'd0)) begin
            shrink_amt = shrink_amt - 16'd1;
        end
        if (shrink_amt == 16'd0) begin
            shrink_amt = 16'd1;
        end
    end

    // Fix-up for a grow: cap at four times, force a change, saturate.
    // With a zero target the quotient counts as unbounded.
    always_comb begin
        amt4   = {r_amount, 2'b00};
        grow_q = (r_div == 16'd0) ? {14'd0, amt4} : r_acc;
        if (grow_q > {14'd0, amt4}) begin
            grow_q = {14'd0, amt4};
        end
        if (grow_q == {16'd0, r_amount}) begin
            grow_q = grow_q + 32'd1;
        end
        grow_amt = (grow_q > 32'h0000_FFFF) ? 16'hFFFF : grow_q[15:0];
    end

    // Control and block state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win        <= WINDOW_TICKS_RESET;
            r_scale      <= RATE_SCALE_RESET;
            r_low_t      <= LOW_TARGET_RESET;
            r_high_t     <= HIGH_TARGET_RESET;
            r_lpf        <= LOW_PRIO_RESET;
            r_init       <= INITIAL_AMOUNT_RESET;
            r_count      <= 16'd0;
            r_rate       <= RATE_RESET;
            r_window_end <= {16'd0, WINDOW_TICKS_RESET};
            r_amount     <= INITIAL_AMOUNT_RESET;
            r_state      <= S_IDLE;
            r_cnt        <= 5'd0;
            r_stage      <= 1'b0;
            r_grow       <= 1'b0;
            r_adj        <= 1'b0;
            r_closed     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WINDOW_TICKS:        r_win    <= i_cfg_data;
                    CFG_RATE_SCALE:          r_scale  <= i_cfg_data[7:0];
                    CFG_LOW_TARGET:          r_low_t  <= i_cfg_data[7:0];
                    CFG_HIGH_TARGET:         r_high_t <= i_cfg_data[7:0];
                    CFG_LOW_PRIORITY_FACTOR: r_lpf    <= i_cfg_data[7:0];
                    CFG_INITIAL_AMOUNT:      r_init   <= i_cfg_data;
                    default: ;
                endcase
            end

            r_out_valid <= load_out || (r_out_valid && i_out_stall);

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_in_item.mode == MODE_WORK_DONE) begin
                            r_amount <= r_init;
                            r_closed <= 1'b0;
                            r_state  <= S_DONE;
                        end else if (closes) begin
                            r_count      <= 16'd0;
                            r_window_end <= i_in_item.tick + {16'd0, r_win};
                            r_closed     <= 1'b1;
                            r_adj        <= i_in_item.adjust_enable;
                            r_cnt        <= 5'd0;
                            r_state      <= S_MULR;
                        end else begin
                            r_count  <= cnt_inc;
                            r_closed <= 1'b0;
                            r_state  <= S_DONE;
                        end
                    end
                end
                S_MULR: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == MULR_LAST) begin
                        r_rate  <= rate_sat;
                        r_stage <= 1'b0;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_cnt <= 5'd0;
                    if (!r_stage) begin
                        if (r_adj && (r_rate <= r_lo)) begin
                            r_grow  <= 1'b0;
                            r_state <= S_MULA;
                        end else begin
                            r_stage <= 1'b1;
                        end
                    end else begin
                        if (r_adj && (r_rate > r_hi)) begin
                            r_grow  <= 1'b1;
                            r_state <= S_MULA;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_MULA: begin
                    if (r_cnt == MULA_LAST) begin
                        r_cnt   <= 5'd0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    if (r_grow) begin
                        r_amount <= grow_amt;
                        r_state  <= S_DONE;
                    end else begin
                        r_amount <= shrink_amt;
                        r_stage  <= 1'b1;
                        r_state  <= S_CHK;
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Serial datapath and output register.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_acc   <= 32'd0;
                r_mq    <= {r_scale, 8'd0};
                r_mcand <= cnt_inc;
                r_fq    <= i_in_item.high_priority ? 8'd1 : r_lpf;
                r_lo    <= 16'd0;
                r_hi    <= 16'd0;
            end
            S_MULR: begin
                r_acc <= n_acc_mul;
                r_mq  <= {r_mq[14:0], 1'b0};
                r_fq  <= {r_fq[6:0], 1'b0};
                r_lo  <= n_lo;
                r_hi  <= n_hi;
            end
            S_CHK: begin
                r_acc   <= 32'd0;
                r_mq    <= r_rate;
                r_mcand <= r_amount;
                r_div   <= r_stage ? r_hi : r_lo;
            end
            S_MULA: begin
                r_acc <= n_acc_mul;
                r_mq  <= {r_mq[14:0], 1'b0};
                r_rem <= 16'd0;
            end
            S_DIV: begin
                r_acc <= {r_acc[30:0], div_q};
                r_rem <= div_rem;
            end
            default: ;
        endcase

        if (load_out) begin
            r_out.work_amount   <= r_amount;
            r_out.idle_rate     <= r_rate;
            r_out.window_closed <= r_closed;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/irwag_checker.sv
// Port-level checks for the idle-rate work-amount governor and their binding.
`default_nettype none

module irwag_checker (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    input  wire                     o_in_stall,
    input  wire                     o_out_valid,
    input  wire                     i_out_stall,
    input  irwag_pkg::t_out_item    o_out_item
);
    import irwag_pkg::*;

    // A stalled result beat stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result beat changed while stalled");

    // The block works on one beat at a time: it is busy right after an accept.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again straight after an accept");

    // A fresh result lands exactly as the block turns idle again.
    a_result_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall)
        else $error("result appeared while the block was still busy");

    // Reset empties the output and leaves the block ready.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("block not idle and empty after reset");

endmodule

bind idle_rate_work_amount_governor irwag_checker u_irwag_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire
